// ----- hw/rtl/rsrg_pkg.sv -----
// ============================================================================
// rsrg_pkg
// Shared types and constants for the refcounted shared register gate.
// ============================================================================
package rsrg_pkg;

  // Sizes
  localparam int MAX_ENTRIES = 16;
  localparam int ENTRY_IW    = $clog2(MAX_ENTRIES);
  localparam int REG_WORDS   = 256;
  localparam int WORD_IW     = $clog2(REG_WORDS);
  localparam int COUNT_BITS  = 16;

  // Field widths
  localparam int OFFSET_W    = 10;
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = 4;
  localparam int ENT_OFF_W   = 8;
  localparam int SCOUNT_W    = 5;
  localparam int ADDR_W      = 3;

  // Stream payload widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  // Configuration register indexes
  localparam logic REG_SIGNAL_COUNT = 1'b0;
  localparam logic REG_LAST_OFFSET  = 1'b1;

  localparam logic [OFFSET_W-1:0] LAST_OFFSET_RESET = OFFSET_W'(1020);

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_REFUSED   = 3'd1,
    STATUS_UNDERFLOW = 3'd2,
    STATUS_OVERFLOW  = 3'd3,
    STATUS_RANGE     = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // input transfer: latch item, read store, run search
    logic commit;      // apply the access and load the output register
    logic clear_step;  // zero one store word
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // last store word is being cleared
  } ctrl_stat_t;

endpackage

// ----- hw/rtl/rsrg_ctrl.sv -----
// ============================================================================
// rsrg_ctrl
// Sequencer: store clearing pass, item capture and commit, output valid.
// ============================================================================
module rsrg_ctrl
  import rsrg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;
  logic   out_free;
  logic   s_accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  // Command decode
  always_comb begin
    cmd.capture    = s_accept;
    cmd.commit     = (state == ST_EXEC) && out_free;
    cmd.clear_step = (state == ST_CLEAR);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Output valid: set by commit, dropped once the transfer completes
  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.commit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // One item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("commit did not present a result");

  a_exec_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && !out_free |=> (state == ST_EXEC))
    else $error("left execute with the output register still full");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready && !m_tvalid)
    else $error("traffic during the clearing pass");

endmodule

// ----- hw/rtl/rsrg_datapath.sv -----
// ============================================================================
// rsrg_datapath
// Register store, signal table, entry search and the count/RMW arithmetic.
// ============================================================================
module rsrg_datapath
  import rsrg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  input  logic [SCOUNT_W-1:0]   signal_count,
  input  logic [OFFSET_W-1:0]   last_offset,
  input  cmd_t                  in_cmd,
  input  logic [OFFSET_W-1:0]   in_offset,
  input  logic [DATA_W-1:0]     in_mask,
  input  logic [DATA_W-1:0]     in_value,
  input  logic [SLOT_W-1:0]     in_slot,
  output logic [DATA_W-1:0]     read_data,
  output status_t               status,
  output logic                  register_written,
  output logic                  signal_present,
  output logic [COUNT_BITS-1:0] enable_count
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Storage
  logic [DATA_W-1:0]     store [REG_WORDS];
  logic [ENT_OFF_W-1:0]  ent_off [MAX_ENTRIES];
  logic [DATA_W-1:0]     ent_mask [MAX_ENTRIES];
  logic [DATA_W-1:0]     ent_en [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] ent_cnt [MAX_ENTRIES];
  logic [WORD_IW-1:0]    clr_addr;

  // Captured item
  cmd_t                q_cmd;
  logic [WORD_IW-1:0]  q_word;
  logic [DATA_W-1:0]   q_mask;
  logic [DATA_W-1:0]   q_value;
  logic [SLOT_W-1:0]   q_slot;
  logic                q_range_err;
  logic                q_hit;
  logic [ENTRY_IW-1:0] q_hit_idx;
  logic                q_present;
  logic [DATA_W-1:0]   rdata;

  // Search signals
  logic [MAX_ENTRIES-1:0] same_word, full_hit;
  logic                s_hit;
  logic [ENTRY_IW-1:0] s_hit_idx;
  logic                s_present;
  logic                s_range_err;

  // Execute signals
  logic [COUNT_BITS-1:0] cnt_cur, cnt_new;
  logic                  en_match;
  logic                  cnt_we;
  logic                  store_we;
  logic [DATA_W-1:0]     store_new;
  logic [DATA_W-1:0]     rd_res;
  status_t               st_res;
  logic                  present_res;
  logic [COUNT_BITS-1:0] cnt_res;

  assign stat.clear_last = (32'(clr_addr) == REG_WORDS - 1);

  // Entry search on the incoming item
  always_comb begin
    logic [WORD_IW-1:0] w;
    w = in_offset[OFFSET_W-1:2];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      same_word[i] = (ent_off[i] == ENT_OFF_W'(w)) && (SCOUNT_W'(i) < signal_count);
      full_hit[i]  = same_word[i] && ((in_mask == '0) || (ent_mask[i] == in_mask));
    end
    s_hit     = |full_hit;
    s_hit_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (full_hit[i]) s_hit_idx = ENTRY_IW'(i);
    end
    // a load makes its own slot match, if that slot is in use
    if (in_cmd == CMD_LOAD) begin
      s_present = (SCOUNT_W'(in_slot) < signal_count) && (32'(in_slot) < MAX_ENTRIES);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (same_word[i] && (SLOT_W'(i) != in_slot)) s_present = 1'b1;
      end
    end else begin
      s_present = |same_word;
    end
    s_range_err = (in_offset > last_offset) || (32'(w) >= REG_WORDS);
  end

  // Capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_cmd       <= in_cmd;
      q_word      <= in_offset[OFFSET_W-1:2];
      q_mask      <= in_mask;
      q_value     <= in_value;
      q_slot      <= in_slot;
      q_range_err <= s_range_err;
      q_hit       <= s_hit;
      q_hit_idx   <= s_hit_idx;
      q_present   <= s_present;
    end
  end

  // Count update and masked read-modify-write
  always_comb begin
    cnt_cur     = ent_cnt[q_hit_idx];
    en_match    = (ent_en[q_hit_idx] == q_value);
    cnt_new     = cnt_cur;
    cnt_we      = 1'b0;
    store_we    = 1'b0;
    store_new   = rdata;
    rd_res      = rdata;
    st_res      = STATUS_OK;
    present_res = q_present;
    cnt_res     = '0;
    unique case (q_cmd)
      CMD_LOAD: begin
        rd_res = rdata;
      end
      CMD_READ, CMD_WRITE, CMD_UPDATE: begin
        if (q_range_err) begin
          st_res      = STATUS_RANGE;
          rd_res      = '0;
          present_res = 1'b0;
        end else if (q_cmd == CMD_WRITE) begin
          if (q_present) begin
            st_res = STATUS_REFUSED;
          end else begin
            store_we  = 1'b1;
            store_new = q_value;
          end
          rd_res = store_new;
        end else if (q_cmd == CMD_UPDATE) begin
          if (q_hit) begin
            cnt_we = 1'b1;
            if (en_match) begin
              if (cnt_cur == '0) begin
                cnt_new  = COUNT_BITS'(1);
                store_we = 1'b1;
              end else if (cnt_cur == COUNT_MAX) begin
                st_res = STATUS_OVERFLOW;
              end else begin
                cnt_new = cnt_cur + COUNT_BITS'(1);
              end
            end else begin
              if (cnt_cur == '0) begin
                st_res = STATUS_UNDERFLOW;
              end else begin
                cnt_new  = cnt_cur - COUNT_BITS'(1);
                store_we = (cnt_cur == COUNT_BITS'(1));
              end
            end
            cnt_res = cnt_new;
          end else begin
            store_we = 1'b1;
          end
          if (store_we) store_new = (rdata & ~q_mask) | (q_value & q_mask);
          rd_res = store_new;
        end else begin
          rd_res = rdata;
        end
      end
      default: rd_res = rdata;
    endcase
  end

  // Register store: read on capture, write on commit or clearing pass
  always_ff @(posedge clk) begin
    if (cmd.capture) rdata <= store[in_offset[OFFSET_W-1:2]];
    if (cmd.clear_step) begin
      store[clr_addr] <= '0;
    end else if (cmd.commit && store_we) begin
      store[q_word] <= store_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + WORD_IW'(1);
    end
  end

  // Signal table contents
  always_ff @(posedge clk) begin
    if (cmd.commit && (q_cmd == CMD_LOAD) && (32'(q_slot) < MAX_ENTRIES)) begin
      ent_off[q_slot[ENTRY_IW-1:0]]  <= ENT_OFF_W'(q_word);
      ent_mask[q_slot[ENTRY_IW-1:0]] <= q_mask;
      ent_en[q_slot[ENTRY_IW-1:0]]   <= q_value;
    end
  end

  // Enable counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) ent_cnt[i] <= '0;
    end else if (cmd.commit) begin
      if ((q_cmd == CMD_LOAD) && (32'(q_slot) < MAX_ENTRIES)) begin
        ent_cnt[q_slot[ENTRY_IW-1:0]] <= '0;
      end else if (cnt_we && !q_range_err) begin
        ent_cnt[q_hit_idx] <= cnt_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data        <= rd_res;
      status           <= st_res;
      register_written <= store_we && !q_range_err;
      signal_present   <= present_res;
      enable_count     <= cnt_res;
    end
  end

endmodule

// ----- hw/rtl/refcounted_shared_register_gate.sv -----
// ============================================================================
// refcounted_shared_register_gate
// Register file behind a reference-counted table of shared bit-field signals.
// ============================================================================
// One access (read, write, update bits or table load) runs as a capture step,
// which reads the register store and searches the 16-entry signal table on
// input transfer, then a commit step, which applies the count change and the
// masked read-modify-write through the single store port. A new item is taken
// only after the previous one has committed, and commit waits while the output
// register still holds an unaccepted result. After reset the block clears its
// 256-word register store, one word per cycle, and takes no item until the
// clearing pass ends; configuration writes are taken throughout.
module refcounted_shared_register_gate
  import rsrg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // access requests
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // offset, bit_mask, data_value, entry_index
  input  logic [1:0]             s_tuser,  // cmd
  // results
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // read_data, status, register_written,
                                           // signal_present, enable_count
);

  logic [SCOUNT_W-1:0]   signal_count;
  logic [OFFSET_W-1:0]   last_offset;
  ctrl_cmd_t             ccmd;
  ctrl_stat_t            cstat;
  logic [DATA_W-1:0]     read_data;
  status_t               status;
  logic                  register_written;
  logic                  signal_present;
  logic [COUNT_BITS-1:0] enable_count;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      signal_count <= '0;
      last_offset  <= LAST_OFFSET_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SIGNAL_COUNT) signal_count <= pwdata[SCOUNT_W-1:0];
      else                              last_offset  <= pwdata[OFFSET_W-1:0];
    end
  end

  // Register read-back
  always_comb begin
    if (paddr[2] == REG_SIGNAL_COUNT) prdata = 32'(signal_count);
    else                              prdata = 32'(last_offset);
  end

  rsrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (cstat),
    .cmd      (ccmd)
  );

  rsrg_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ccmd),
    .stat             (cstat),
    .signal_count     (signal_count),
    .last_offset      (last_offset),
    .in_cmd           (cmd_t'(s_tuser)),
    .in_offset        (s_tdata[9:0]),
    .in_mask          (s_tdata[41:10]),
    .in_value         (s_tdata[73:42]),
    .in_slot          (s_tdata[77:74]),
    .read_data        (read_data),
    .status           (status),
    .register_written (register_written),
    .signal_present   (signal_present),
    .enable_count     (enable_count)
  );

  // Result transfer packing
  assign m_tdata = {3'b000, enable_count, signal_present, register_written,
                    status, read_data};

endmodule
